/* rtl/athermo_pkg.sv */
package athermo_pkg;

    // Window depth and field widths
    localparam int DEF_SAMPLE_COUNT = 10;
    localparam int TEMP_W           = 8;
    localparam int BLINK_W          = 16;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;

    // Register reset values
    localparam logic [TEMP_W-1:0]  RST_SETPOINT         = 8'd60;
    localparam logic [TEMP_W-1:0]  RST_HYSTERESIS_BAND  = 8'd5;
    localparam logic [TEMP_W-1:0]  RST_MIN_SETPOINT     = 8'd35;
    localparam logic [TEMP_W-1:0]  RST_MAX_SETPOINT     = 8'd75;
    localparam logic [TEMP_W-1:0]  RST_DEFAULT_SETPOINT = 8'd60;
    localparam logic [BLINK_W-1:0] RST_BLINK_TICKS      = 16'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SETPOINT         = 3'd0,
        REG_HYSTERESIS_BAND  = 3'd1,
        REG_MIN_SETPOINT     = 3'd2,
        REG_MAX_SETPOINT     = 3'd3,
        REG_DEFAULT_SETPOINT = 3'd4,
        REG_BLINK_TICKS      = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_DECIDE = 2'd1,
        PH_COOL   = 2'd2,
        PH_HEAT   = 2'd3
    } phase_t;

    typedef struct packed {
        logic [TEMP_W-1:0] temperature;
        logic              restart;
    } sample_t;

    typedef struct packed {
        logic              heater_drive;
        logic              cooler_drive;
        logic              heat_led;
        logic [1:0]        control_phase;
        logic [TEMP_W-1:0] average_temp;
    } result_t;

    typedef struct packed {
        logic [TEMP_W-1:0]  setpoint;
        logic [TEMP_W-1:0]  hysteresis_band;
        logic [TEMP_W-1:0]  min_setpoint;
        logic [TEMP_W-1:0]  max_setpoint;
        logic [TEMP_W-1:0]  default_setpoint;
        logic [BLINK_W-1:0] blink_ticks;
    } cfg_t;

endpackage

/* rtl/athermo_cell.sv */
module athermo_cell #(
    parameter logic HOME = 1'b0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          restart,
    input  logic [athermo_pkg::TEMP_W-1:0] sample,
    input  logic                          tok_in,
    input  logic [athermo_pkg::TEMP_W-1:0] old_in,
    output logic [athermo_pkg::TEMP_W-1:0] old_out,
    output logic                          sel
);
    import athermo_pkg::*;

    logic [TEMP_W-1:0] val_reg;
    logic              tok_reg;

    // A restart sends the write back to the home cell
    assign sel     = restart ? HOME : tok_reg;
    assign old_out = old_in | (sel ? val_reg : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
            tok_reg <= HOME;
        end
        else if (en)
        begin
            tok_reg <= tok_in;
            if (sel)
            begin
                val_reg <= sample;
            end
        end
    end

endmodule

/* rtl/athermo_window.sv */
module athermo_window #(
    parameter int SAMPLE_COUNT = athermo_pkg::DEF_SAMPLE_COUNT,
    parameter int SUM_W        = $clog2(255 * SAMPLE_COUNT + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          restart,
    input  logic [athermo_pkg::TEMP_W-1:0] sample,
    output logic [SUM_W-1:0]              sum,
    output logic                          fill
);
    import athermo_pkg::*;

    logic [TEMP_W-1:0] old_chain [SAMPLE_COUNT+1];
    logic              sel       [SAMPLE_COUNT];
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;

    assign old_chain[0] = '0;

    genvar k;
    generate
        for (k = 0; k < SAMPLE_COUNT; k++)
        begin : g_cell
            localparam int PREV = (k == 0) ? SAMPLE_COUNT - 1 : k - 1;
            athermo_cell #(
                .HOME ((k == 0) ? 1'b1 : 1'b0)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .restart (restart),
                .sample  (sample),
                .tok_in  (sel[PREV]),
                .old_in  (old_chain[k]),
                .old_out (old_chain[k+1]),
                .sel     (sel[k])
            );
        end
    endgenerate

    // Swap the overwritten sample for the new one in the running sum
    assign sum_next = sum_reg - SUM_W'(old_chain[SAMPLE_COUNT]) + SUM_W'(sample);

    // Writing the next-to-last cell leaves the index at the last slot
    assign fill = sel[SAMPLE_COUNT-2];
    assign sum  = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (en)
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

/* rtl/athermo_ctrl.sv */
module athermo_ctrl #(
    parameter int SAMPLE_COUNT = athermo_pkg::DEF_SAMPLE_COUNT,
    parameter int SUM_W        = $clog2(255 * SAMPLE_COUNT + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 restart,
    input  logic                 fill,
    input  logic [SUM_W-1:0]     sum,
    input  athermo_pkg::cfg_t    cfg,
    output athermo_pkg::result_t result
);
    import athermo_pkg::*;

    // Mean by reciprocal multiply; exact for every sum below 2**SUM_W
    localparam int SHIFT   = SUM_W + 4;
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << SHIFT) + SAMPLE_COUNT - 1) / SAMPLE_COUNT);

    phase_t              ph_reg,  ph_next,  ph_cur;
    logic [BLINK_W-1:0]  bc_reg,  bc_next,  bc_inc;
    logic [TEMP_W-1:0]   act_reg, act_next, sp_sel;
    logic                heat_reg, heat_next;
    logic                cool_reg, cool_next;
    logic                led_reg,  led_next;
    logic [PROD_W-1:0]   prod;
    logic [TEMP_W-1:0]   avg;
    logic [TEMP_W:0]     avg9, band9, act9;

    assign prod  = PROD_W'(sum) * PROD_W'(RECIP);
    assign avg   = prod[SHIFT +: TEMP_W];
    assign avg9  = {1'b0, avg};
    assign band9 = {1'b0, cfg.hysteresis_band};
    assign act9  = {1'b0, act_reg};
    assign bc_inc = bc_reg + BLINK_W'(1);

    always_comb
    begin
        ph_cur    = restart ? PH_WAIT : ph_reg;
        ph_next   = ph_cur;
        heat_next = restart ? 1'b0 : heat_reg;
        cool_next = restart ? 1'b0 : cool_reg;
        led_next  = restart ? 1'b0 : led_reg;
        bc_next   = bc_reg;
        act_next  = act_reg;
        sp_sel    = (cfg.setpoint > cfg.max_setpoint || cfg.setpoint < cfg.min_setpoint)
                    ? cfg.default_setpoint : cfg.setpoint;
        unique case (ph_cur)
            PH_WAIT:
            begin
                if (fill)
                begin
                    ph_next = PH_DECIDE;
                end
            end
            PH_DECIDE:
            begin
                act_next = sp_sel;
                ph_next  = (avg < sp_sel) ? PH_HEAT : PH_COOL;
                led_next = 1'b0;
            end
            PH_COOL:
            begin
                heat_next = 1'b0;
                cool_next = 1'b1;
                led_next  = 1'b1;
                if (avg9 + band9 <= act9)
                begin
                    ph_next = PH_HEAT;
                end
            end
            PH_HEAT:
            begin
                cool_next = 1'b0;
                heat_next = 1'b1;
                bc_next   = bc_inc;
                if (avg9 >= act9 + band9)
                begin
                    ph_next = PH_COOL;
                end
                if (bc_inc > cfg.blink_ticks)
                begin
                    bc_next  = '0;
                    led_next = ~led_next;
                end
            end
            default:
            begin
                ph_next = PH_WAIT;
            end
        endcase
    end

    assign result.heater_drive  = heat_next;
    assign result.cooler_drive  = cool_next;
    assign result.heat_led      = led_next;
    assign result.control_phase = ph_next;
    assign result.average_temp  = avg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_WAIT;
            bc_reg   <= '0;
            act_reg  <= RST_DEFAULT_SETPOINT;
            heat_reg <= 1'b0;
            cool_reg <= 1'b0;
            led_reg  <= 1'b0;
        end
        else if (step)
        begin
            ph_reg   <= ph_next;
            bc_reg   <= bc_next;
            act_reg  <= act_next;
            heat_reg <= heat_next;
            cool_reg <= cool_next;
            led_reg  <= led_next;
        end
    end

endmodule

/* rtl/averaged_hysteresis_thermostat.sv */
// Moving-average bang-bang thermostat. Every sample item yields one result item holding the
// drive outputs, the LED, the control phase and the truncated mean of the last SAMPLE_COUNT
// samples. It takes one item per clock cycle unless the output stalls. The window is a ring
// of cells with a write token; a running sum is registered on acceptance. In the second
// stage, a reciprocal multiply forms the mean, the phase controller steps and the result is
// registered in the output register. A restart item moves the token back to the first cell.
// It forces the waiting phase and clears the heater, cooler and LED. It keeps the stored
// samples and the blink counter. Reset clears the window. Writes to setpoint, limits and
// default setpoint take effect at the next deciding phase; band and blink count apply from
// the next item on. Configuration is written through the cfg channel, which is always
// ready. Write it only while no item is in flight; the block does not enforce this.
module averaged_hysteresis_thermostat #(
    parameter int SAMPLE_COUNT = athermo_pkg::DEF_SAMPLE_COUNT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_ready,
    input  athermo_pkg::sample_t               sample,
    output logic                               result_valid,
    input  logic                               result_ready,
    output athermo_pkg::result_t               result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [athermo_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [athermo_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import athermo_pkg::*;

    localparam int SUM_W = $clog2(255 * SAMPLE_COUNT + 1);

    cfg_t             cfg_reg;
    logic             accept;
    logic             advance;
    logic             step;
    logic [SUM_W-1:0] sum;
    logic             fill;
    logic             b_valid_reg;
    logic             b_restart_reg;
    logic             b_fill_reg;
    result_t          ctrl_result;
    result_t          result_reg;
    logic             result_valid_reg;

    // Config registers: always ready, unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint         <= RST_SETPOINT;
            cfg_reg.hysteresis_band  <= RST_HYSTERESIS_BAND;
            cfg_reg.min_setpoint     <= RST_MIN_SETPOINT;
            cfg_reg.max_setpoint     <= RST_MAX_SETPOINT;
            cfg_reg.default_setpoint <= RST_DEFAULT_SETPOINT;
            cfg_reg.blink_ticks      <= RST_BLINK_TICKS;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_SETPOINT:         cfg_reg.setpoint         <= cfg_data[TEMP_W-1:0];
                REG_HYSTERESIS_BAND:  cfg_reg.hysteresis_band  <= cfg_data[TEMP_W-1:0];
                REG_MIN_SETPOINT:     cfg_reg.min_setpoint     <= cfg_data[TEMP_W-1:0];
                REG_MAX_SETPOINT:     cfg_reg.max_setpoint     <= cfg_data[TEMP_W-1:0];
                REG_DEFAULT_SETPOINT: cfg_reg.default_setpoint <= cfg_data[TEMP_W-1:0];
                REG_BLINK_TICKS:      cfg_reg.blink_ticks      <= cfg_data[BLINK_W-1:0];
                default:              ;
            endcase
        end
    end

    // Pipeline flow: the output register frees up when empty or when taken
    assign advance      = !result_valid_reg || result_ready;
    assign step         = b_valid_reg && advance;
    assign sample_ready = !b_valid_reg || advance;
    assign accept       = sample_valid && sample_ready;

    // First stage: write the sample into the ring and update the running sum
    athermo_window #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .SUM_W        (SUM_W)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (accept),
        .restart (sample.restart),
        .sample  (sample.temperature),
        .sum     (sum),
        .fill    (fill)
    );

    // Hold the item's flags next to the sum it produced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_restart_reg <= sample.restart;
            b_fill_reg    <= fill;
        end
    end

    // Second stage: mean and phase controller
    athermo_ctrl #(
        .SAMPLE_COUNT (SAMPLE_COUNT),
        .SUM_W        (SUM_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .restart (b_restart_reg),
        .fill    (b_fill_reg),
        .sum     (sum),
        .cfg     (cfg_reg),
        .result  (ctrl_result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= ctrl_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
